>>> rtl/core/logic_formula_lexer_top_macros.svh
// Assertion macros shared by the lexer RTL.
`ifndef LOGIC_FORMULA_LEXER_TOP_MACROS_SVH
`define LOGIC_FORMULA_LEXER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LFL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lfl_pkg.sv
// Shared types, codes and character classes of the formula lexer.
package lfl_pkg;

  typedef logic [3:0] kind_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] mode_t;

  // Number of entries in the result queue of the lexer.
  localparam int QDEPTH = 4;

  localparam kind_t KIND_IDENT   = 4'd0;
  localparam kind_t KIND_NUMBER  = 4'd1;
  localparam kind_t KIND_LBRACK  = 4'd2;
  localparam kind_t KIND_RBRACK  = 4'd3;
  localparam kind_t KIND_LPAREN  = 4'd4;
  localparam kind_t KIND_RPAREN  = 4'd5;
  localparam kind_t KIND_COMMA   = 4'd6;
  localparam kind_t KIND_COLON   = 4'd7;
  localparam kind_t KIND_AT      = 4'd8;
  localparam kind_t KIND_NEWLINE = 4'd9;
  localparam kind_t KIND_UNKNOWN = 4'd10;

  localparam mode_t MODE_IDLE    = 2'd0;
  localparam mode_t MODE_IDENT   = 2'd1;
  localparam mode_t MODE_NUMBER  = 2'd2;
  localparam mode_t MODE_COMMENT = 2'd3;

  localparam byte_t CH_LBRACK  = 8'h5B;
  localparam byte_t CH_RBRACK  = 8'h5D;
  localparam byte_t CH_LPAREN  = 8'h28;
  localparam byte_t CH_RPAREN  = 8'h29;
  localparam byte_t CH_COMMA   = 8'h2C;
  localparam byte_t CH_COLON   = 8'h3A;
  localparam byte_t CH_AT      = 8'h40;
  localparam byte_t CH_HASH    = 8'h23;
  localparam byte_t CH_NEWLINE = 8'h0A;
  localparam byte_t CH_USCORE  = 8'h5F;
  localparam byte_t CH_SPACE   = 8'h20;
  localparam byte_t CH_TAB     = 8'h09;
  localparam byte_t CH_CR      = 8'h0D;

  typedef struct packed {
    kind_t kind;
    byte_t char_byte;
    logic  token_first;
    logic  token_last;
    logic  step_last;
  } lfl_res_t;

  function automatic logic is_alpha_us(byte_t c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_USCORE;
  endfunction

  function automatic logic is_digit(byte_t c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(byte_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR;
  endfunction

  // Kind of a byte that is not part of a word; blanks and '#' never reach the output.
  function automatic kind_t single_kind(byte_t c);
    kind_t k;
    unique case (c)
      CH_LBRACK:  k = KIND_LBRACK;
      CH_RBRACK:  k = KIND_RBRACK;
      CH_LPAREN:  k = KIND_LPAREN;
      CH_RPAREN:  k = KIND_RPAREN;
      CH_COMMA:   k = KIND_COMMA;
      CH_COLON:   k = KIND_COLON;
      CH_AT:      k = KIND_AT;
      CH_NEWLINE: k = KIND_NEWLINE;
      default:    k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/core/lfl_stream_if.sv
// Valid/ready channel interfaces for the lexer input bytes and output results.
interface lfl_in_if;
  import lfl_pkg::*;
  logic  valid;
  logic  ready;
  byte_t ch;
  logic  end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface lfl_out_if;
  import lfl_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t char_byte;
  logic  token_first;
  logic  token_last;
  logic  step_last;

  modport source (output valid, output kind, output char_byte, output token_first,
                  output token_last, output step_last, input ready);
  modport sink   (input valid, input kind, input char_byte, input token_first,
                  input token_last, input step_last, output ready);
endinterface

>>> rtl/core/logic_formula_lexer_top.sv
// Byte-serial tokenizer for a small logic-formula language, one byte per request.
//
// Usage: in_chan carries one text byte per request (ch) plus end_of_input, which
// flushes a pending word character and closes an open comment. out_chan carries
// one token character per request with its kind, first/last-of-token marks and
// step_last, which flags the final result caused by one input request.
// An input request gives zero, one or two results. Word characters are held back
// one byte, because only the following byte shows whether the word has ended.
// Results of an input request are computed in the accepting cycle and enter a
// four-entry result queue, whose head is offered on out_chan. Input takes one
// request per cycle while the queue holds at most two results; output drains
// one result per cycle while the receiver is ready, so a byte that ends a word
// and starts a single-character token gives two results to drain.
// The queue head is the output register, so input keeps flowing while a result
// waits. When the receiver stalls the queue fills and in_chan.ready drops once
// more than two results are waiting. Synchronous active-low reset empties the
// queue and returns the lexer to idle with nothing pending.
`include "logic_formula_lexer_top_macros.svh"

module logic_formula_lexer_top (
  input  logic      clk,
  input  logic      rst_n,
  lfl_in_if.sink    in_chan,
  lfl_out_if.source out_chan
);
  import lfl_pkg::*;

  // Lexer state.
  mode_t mode_r, mode_nxt;
  byte_t held_r, held_nxt;
  logic  first_r, first_nxt;

  // Result queue; entry 0 is the output register.
  lfl_res_t   q_r [QDEPTH];
  lfl_res_t   q_nxt [QDEPTH];
  lfl_res_t   q_shift [QDEPTH];
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] base;

  logic     acc, pop;
  lfl_res_t res0, res1;
  logic [1:0] nres;

  // Idle-side handling of the current byte.
  byte_t c;
  logic  c_alpha, c_digit, c_word, idle_emit;
  mode_t idle_mode;

  assign acc = in_chan.valid && in_chan.ready;
  assign pop = out_chan.valid && out_chan.ready;
  assign in_chan.ready = cnt_r <= 3'd2;

  assign c       = in_chan.ch;
  assign c_alpha = is_alpha_us(c);
  assign c_digit = is_digit(c);
  assign c_word  = c_alpha || c_digit;
  // A byte seen in idle emits itself unless it starts a word, a comment or is a blank.
  assign idle_emit = !c_word && !is_blank(c) && c != CH_HASH;

  always_comb begin
    if (c_alpha) begin
      idle_mode = MODE_IDENT;
    end else if (c_digit) begin
      idle_mode = MODE_NUMBER;
    end else if (c == CH_HASH) begin
      idle_mode = MODE_COMMENT;
    end else begin
      idle_mode = MODE_IDLE;
    end
  end

  // Next lexer state and the results of the current byte.
  always_comb begin
    kind_t wkind;
    logic  cont;
    wkind     = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
    cont      = (mode_r == MODE_IDENT) ? c_word : c_digit;
    mode_nxt  = mode_r;
    held_nxt  = held_r;
    first_nxt = first_r;
    nres      = 2'd0;
    res0      = '{kind: wkind, char_byte: held_r, token_first: first_r,
                  token_last: 1'b1, step_last: 1'b0};
    res1      = '{kind: single_kind(c), char_byte: c, token_first: 1'b1,
                  token_last: 1'b1, step_last: 1'b1};

    if (in_chan.end_of_input) begin
      // Flush a held word character; a comment simply closes.
      if (mode_r == MODE_IDENT || mode_r == MODE_NUMBER) begin
        nres = 2'd1;
      end
      mode_nxt  = MODE_IDLE;
      first_nxt = 1'b0;
    end else if (mode_r == MODE_COMMENT) begin
      // Only the newline or end of input leaves a comment; the newline is still a token.
      if (c == CH_NEWLINE) begin
        mode_nxt = MODE_IDLE;
        res0     = res1;
        nres     = 2'd1;
      end
    end else if (mode_r == MODE_IDENT || mode_r == MODE_NUMBER) begin
      if (cont) begin
        res0.token_last = 1'b0;
        nres            = 2'd1;
        held_nxt        = c;
        first_nxt       = 1'b0;
      end else begin
        // The held character closes its word; the byte is then taken as in idle.
        nres      = idle_emit ? 2'd2 : 2'd1;
        mode_nxt  = idle_mode;
        first_nxt = c_word;
        if (c_word) begin
          held_nxt = c;
        end
      end
    end else begin
      mode_nxt = idle_mode;
      res0     = res1;
      nres     = idle_emit ? 2'd1 : 2'd0;
      if (c_word) begin
        held_nxt  = c;
        first_nxt = 1'b1;
      end
    end
    res0.step_last = (nres == 2'd1);
  end

  // Queue update: drop the head on a pop, then append the new results.
  assign base = cnt_r - {2'b00, pop};

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_shift[i] = q_r[i + 1];
      end else begin
        q_shift[i] = q_r[i];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (acc && nres != 2'd0 && 3'(i) == base) begin
        q_nxt[i] = res0;
      end else if (acc && nres == 2'd2 && 3'(i) == base + 3'd1) begin
        q_nxt[i] = res1;
      end else begin
        q_nxt[i] = q_shift[i];
      end
    end
    cnt_nxt = acc ? base + {1'b0, nres} : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      held_r  <= '0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        mode_r  <= mode_nxt;
        held_r  <= held_nxt;
        first_r <= first_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_chan.valid       = cnt_r != 3'd0;
  assign out_chan.kind        = q_r[0].kind;
  assign out_chan.char_byte   = q_r[0].char_byte;
  assign out_chan.token_first = q_r[0].token_first;
  assign out_chan.token_last  = q_r[0].token_last;
  assign out_chan.step_last   = q_r[0].step_last;

  // The queue must have room for two results whenever a byte is taken.
  `LFL_ASSERT_SAME(a_room_on_accept, acc, cnt_r <= 3'd2, "byte accepted without queue room")
  // End of input always leaves the lexer idle with nothing pending.
  `LFL_ASSERT_NEXT(a_eoi_idle, acc && in_chan.end_of_input,
                   mode_r == MODE_IDLE && !first_r, "end of input did not return to idle")
  // A delivered result with no new byte shrinks the queue by exactly one.
  `LFL_ASSERT_NEXT(a_pop_count, pop && !acc, cnt_r == $past(cnt_r) - 3'd1,
                   "queue count wrong after pop")

endmodule
